// ----- rtl/month_calendar_grid_unit_macros.svh -----
// assertion macros shared by the month calendar grid rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MONTH_CALENDAR_GRID_UNIT_MACROS_SVH
`define MONTH_CALENDAR_GRID_UNIT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define MCG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcg assertion failed");

// next-cycle implication, quiet while in reset
`define MCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcg assertion failed");

`endif

// ----- rtl/mcg_pkg.sv -----
// shared types, microcode encoding and calendar tables for the month grid unit
// no dependencies
package mcg_pkg;

  localparam int unsigned YearMax   = 9999;
  localparam int unsigned YearShift = 400;
  localparam int unsigned StepW     = 4;

  typedef logic [StepW-1:0] step_t;

  // step addresses of the control store
  localparam step_t StepIdle  = 4'd0;
  localparam step_t StepEra   = 4'd1;
  localparam step_t StepYoe   = 4'd2;
  localparam step_t StepCent  = 4'd3;
  localparam step_t StepSum   = 4'd4;
  localparam step_t StepDiv7  = 4'd5;
  localparam step_t StepMod7  = 4'd6;
  localparam step_t StepFix7  = 4'd7;
  localparam step_t StepLead  = 4'd8;
  localparam step_t StepCheck = 4'd9;
  localparam step_t StepBlank = 4'd10;
  localparam step_t StepDays  = 4'd11;
  localparam step_t StepDone  = 4'd12;
  localparam step_t StepErr   = 4'd13;

  typedef struct packed {
    logic [13:0] year_value;
    logic [3:0]  month_value;
  } in_item_t;

  typedef struct packed {
    logic       cell_blank;
    logic [4:0] day_number;
    logic       last_cell;
    logic       month_error;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ERA,
    OP_YOE,
    OP_CENT,
    OP_SUM,
    OP_DIV7,
    OP_MOD7,
    OP_FIX7,
    OP_LEAD,
    OP_DEC_LEAD,
    OP_INC_DAY
  } dp_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_MONTH_BAD,
    COND_LEAD_ZERO,
    COND_LEAD_GT1,
    COND_DAY_NE_LEN
  } cond_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_BLANK,
    EMIT_DAY,
    EMIT_ERR
  } emit_e;

  typedef struct packed {
    logic   take_in;
    emit_e  emit;
    dp_op_e op;
    cond_e  cond;
    step_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic slot_free;
    logic month_bad;
    logic lead_zero;
    logic lead_gt1;
    logic day_ne_len;
  } dp_status_t;

  // day of the shifted year (march based) on which the 1st of month index mp falls
  function automatic logic [9:0] doy_of(input logic [3:0] mp);
    logic [9:0] d;
    case (mp)
      4'd0:    d = 10'd0;
      4'd1:    d = 10'd31;
      4'd2:    d = 10'd61;
      4'd3:    d = 10'd92;
      4'd4:    d = 10'd122;
      4'd5:    d = 10'd153;
      4'd6:    d = 10'd184;
      4'd7:    d = 10'd214;
      4'd8:    d = 10'd245;
      4'd9:    d = 10'd275;
      4'd10:   d = 10'd306;
      4'd11:   d = 10'd337;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // remainder by seven of a value below 21
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

endpackage

// ----- rtl/mcg_ucode_rom.sv -----
// control store of the month grid sequencer, one control word per step
// depends on mcg_pkg
module mcg_ucode_rom (
  input  mcg_pkg::step_t      step_i,
  output mcg_pkg::ctrl_word_t ctrl_o
);

  always_comb begin
    ctrl_o = '{take_in: 1'b0, emit: mcg_pkg::EMIT_NONE, op: mcg_pkg::OP_NOP,
               cond: mcg_pkg::COND_ALWAYS, target: mcg_pkg::StepIdle};
    case (step_i)
      mcg_pkg::StepIdle: begin
        ctrl_o.take_in = 1'b1;
        ctrl_o.op      = mcg_pkg::OP_LOAD;
        ctrl_o.cond    = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepEra: begin
        ctrl_o.op     = mcg_pkg::OP_ERA;
        ctrl_o.cond   = mcg_pkg::COND_MONTH_BAD;
        ctrl_o.target = mcg_pkg::StepErr;
      end
      mcg_pkg::StepYoe: begin
        ctrl_o.op   = mcg_pkg::OP_YOE;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepCent: begin
        ctrl_o.op   = mcg_pkg::OP_CENT;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepSum: begin
        ctrl_o.op   = mcg_pkg::OP_SUM;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepDiv7: begin
        ctrl_o.op   = mcg_pkg::OP_DIV7;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepMod7: begin
        ctrl_o.op   = mcg_pkg::OP_MOD7;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepFix7: begin
        ctrl_o.op   = mcg_pkg::OP_FIX7;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepLead: begin
        ctrl_o.op   = mcg_pkg::OP_LEAD;
        ctrl_o.cond = mcg_pkg::COND_NEVER;
      end
      mcg_pkg::StepCheck: begin
        ctrl_o.cond   = mcg_pkg::COND_LEAD_ZERO;
        ctrl_o.target = mcg_pkg::StepDays;
      end
      mcg_pkg::StepBlank: begin
        ctrl_o.emit   = mcg_pkg::EMIT_BLANK;
        ctrl_o.op     = mcg_pkg::OP_DEC_LEAD;
        ctrl_o.cond   = mcg_pkg::COND_LEAD_GT1;
        ctrl_o.target = mcg_pkg::StepBlank;
      end
      mcg_pkg::StepDays: begin
        ctrl_o.emit   = mcg_pkg::EMIT_DAY;
        ctrl_o.op     = mcg_pkg::OP_INC_DAY;
        ctrl_o.cond   = mcg_pkg::COND_DAY_NE_LEN;
        ctrl_o.target = mcg_pkg::StepDays;
      end
      mcg_pkg::StepDone: begin
        ctrl_o.cond   = mcg_pkg::COND_ALWAYS;
        ctrl_o.target = mcg_pkg::StepIdle;
      end
      mcg_pkg::StepErr: begin
        ctrl_o.emit   = mcg_pkg::EMIT_ERR;
        ctrl_o.cond   = mcg_pkg::COND_ALWAYS;
        ctrl_o.target = mcg_pkg::StepIdle;
      end
      default: begin
        ctrl_o.cond   = mcg_pkg::COND_ALWAYS;
        ctrl_o.target = mcg_pkg::StepIdle;
      end
    endcase
  end

endmodule

// ----- rtl/mcg_sequencer.sv -----
// step counter with stall and conditional jump for the month grid unit
// depends on mcg_pkg
module mcg_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcg_pkg::ctrl_word_t ctrl_i,
  input  mcg_pkg::dp_status_t status_i,
  input  logic                in_valid_i,
  output mcg_pkg::step_t      step_o,
  output logic                exec_o,
  output logic                in_ready_o
);

  mcg_pkg::step_t step_q, step_d;
  logic           stall;
  logic           jump;

  // hold the step while waiting for an input or for room in the output register
  assign stall = (ctrl_i.take_in && !in_valid_i) ||
                 ((ctrl_i.emit != mcg_pkg::EMIT_NONE) && !status_i.slot_free);

  always_comb begin
    case (ctrl_i.cond)
      mcg_pkg::COND_NEVER:      jump = 1'b0;
      mcg_pkg::COND_ALWAYS:     jump = 1'b1;
      mcg_pkg::COND_MONTH_BAD:  jump = status_i.month_bad;
      mcg_pkg::COND_LEAD_ZERO:  jump = status_i.lead_zero;
      mcg_pkg::COND_LEAD_GT1:   jump = status_i.lead_gt1;
      mcg_pkg::COND_DAY_NE_LEN: jump = status_i.day_ne_len;
      default:                  jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = ctrl_i.target;
    end else begin
      step_d = step_q + mcg_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mcg_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o     = step_q;
  assign exec_o     = !stall;
  assign in_ready_o = ctrl_i.take_in;

endmodule

// ----- rtl/mcg_datapath.sv -----
// weekday arithmetic, cell counters, config register and output register
// depends on mcg_pkg
module mcg_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcg_pkg::ctrl_word_t ctrl_i,
  input  logic                exec_i,
  input  mcg_pkg::in_item_t   in_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output mcg_pkg::out_item_t  out_data_o,
  output mcg_pkg::dp_status_t status_o
);

  logic [2:0]  ws_q;
  logic [13:0] y_q, y_d;
  logic [3:0]  m_q, m_d;
  logic [3:0]  mp_q, mp_d;
  logic        mbad_q, mbad_d;
  logic [14:0] yy_q, yy_d;
  logic [4:0]  era_q, era_d;
  logic [8:0]  yoe_q, yoe_d;
  logic [1:0]  cent_q, cent_d;
  logic [9:0]  sum_q, sum_d;
  logic [6:0]  q7_q, q7_d;
  logic [3:0]  rem_q, rem_d;
  logic [2:0]  lead_q, lead_d;
  logic [4:0]  len_q, len_d;
  logic [4:0]  day_q, day_d;

  logic               out_valid_q;
  mcg_pkg::out_item_t out_q, out_d;
  logic               emit;

  logic [13:0] ysat;
  logic [14:0] era_prod;
  logic [14:0] era_x400;
  logic [11:0] cent_prod;
  logic [8:0]  cent_x100;
  logic        leap;
  logic [19:0] q7_prod;
  logic [9:0]  q7_x7;
  logic [4:0]  lead_raw;

  assign ysat      = (in_data_i.year_value > 14'(mcg_pkg::YearMax)) ?
                     14'(mcg_pkg::YearMax) : in_data_i.year_value;
  // floor(yy / 400) as floor((yy >> 4) * 41 / 1024), exact below 10400
  assign era_prod  = 15'(yy_q[14:4]) * 15'd41;
  assign era_x400  = 15'(era_q) * 15'(mcg_pkg::YearShift);
  // floor(yoe / 100) the same way
  assign cent_prod = 12'(yoe_q[8:2]) * 12'd41;
  assign cent_x100 = 9'(cent_q) * 9'd100;
  // yoe counts from the year before, so a century year shows as yoe ending in 99
  assign leap      = (m_q == 4'd2) && (y_q[1:0] == 2'b00) &&
                     ((yoe_q != cent_x100 + 9'd99) || (cent_q == 2'd3));
  // quotient by seven, low by at most one
  assign q7_prod   = 20'(sum_q) * 20'd585;
  assign q7_x7     = 10'(q7_q) * 10'd7;
  // weekday minus week start plus a whole week, kept between 1 and 14
  assign lead_raw  = 5'(rem_q) + 5'd8 - 5'(ws_q);

  always_comb begin
    y_d    = y_q;
    m_d    = m_q;
    mp_d   = mp_q;
    mbad_d = mbad_q;
    yy_d   = yy_q;
    era_d  = era_q;
    yoe_d  = yoe_q;
    cent_d = cent_q;
    sum_d  = sum_q;
    q7_d   = q7_q;
    rem_d  = rem_q;
    lead_d = lead_q;
    len_d  = len_q;
    day_d  = day_q;
    if (exec_i) begin
      case (ctrl_i.op)
        mcg_pkg::OP_LOAD: begin
          y_d    = ysat;
          m_d    = in_data_i.month_value;
          mbad_d = (in_data_i.month_value == 4'd0) || (in_data_i.month_value > 4'd12);
          mp_d   = (in_data_i.month_value > 4'd2) ? in_data_i.month_value - 4'd3 :
                                                   in_data_i.month_value + 4'd9;
          yy_d   = 15'(ysat) + 15'(mcg_pkg::YearShift) -
                   15'(in_data_i.month_value <= 4'd2);
        end
        mcg_pkg::OP_ERA:  era_d  = era_prod[14:10];
        mcg_pkg::OP_YOE:  yoe_d  = 9'(yy_q - era_x400);
        mcg_pkg::OP_CENT: cent_d = cent_prod[11:10];
        mcg_pkg::OP_SUM: begin
          sum_d = 10'(yoe_q) + 10'(yoe_q[8:2]) - 10'(cent_q) +
                  mcg_pkg::doy_of(mp_q) + 10'd3;
          len_d = mcg_pkg::month_len(m_q, leap);
        end
        mcg_pkg::OP_DIV7: q7_d  = q7_prod[18:12];
        mcg_pkg::OP_MOD7: rem_d = 4'(sum_q - q7_x7);
        mcg_pkg::OP_FIX7: rem_d = (rem_q >= 4'd7) ? rem_q - 4'd7 : rem_q;
        mcg_pkg::OP_LEAD: begin
          lead_d = mcg_pkg::mod7_small(lead_raw);
          day_d  = 5'd1;
        end
        mcg_pkg::OP_DEC_LEAD: lead_d = lead_q - 3'd1;
        mcg_pkg::OP_INC_DAY:  day_d  = day_q + 5'd1;
        default: ;
      endcase
    end
  end

  assign emit = exec_i && (ctrl_i.emit != mcg_pkg::EMIT_NONE);

  always_comb begin
    out_d = out_q;
    case (ctrl_i.emit)
      mcg_pkg::EMIT_BLANK: out_d = '{cell_blank: 1'b1, day_number: 5'd0,
                                     last_cell: 1'b0, month_error: 1'b0};
      mcg_pkg::EMIT_DAY:   out_d = '{cell_blank: 1'b0, day_number: day_q,
                                     last_cell: day_q == len_q, month_error: 1'b0};
      mcg_pkg::EMIT_ERR:   out_d = '{cell_blank: 1'b0, day_number: 5'd0,
                                     last_cell: 1'b1, month_error: 1'b1};
      default:             out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= 3'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    m_q    <= m_d;
    mp_q   <= mp_d;
    mbad_q <= mbad_d;
    yy_q   <= yy_d;
    era_q  <= era_d;
    yoe_q  <= yoe_d;
    cent_q <= cent_d;
    sum_q  <= sum_d;
    q7_q   <= q7_d;
    rem_q  <= rem_d;
    lead_q <= lead_d;
    len_q  <= len_d;
    day_q  <= day_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.slot_free  = !out_valid_q || out_ready_i;
  assign status_o.month_bad  = mbad_q;
  assign status_o.lead_zero  = (lead_q == 3'd0);
  assign status_o.lead_gt1   = (lead_q > 3'd1);
  assign status_o.day_ne_len = (day_q != len_q);

endmodule

// ----- rtl/month_calendar_grid_unit.sv -----
// top level of the month calendar grid unit
// depends on mcg_pkg, mcg_ucode_rom, mcg_sequencer, mcg_datapath and the macros header

// Takes one (year, month) transaction and returns the cells of that month's view, one
// cell per output transaction: a blank cell for each weekday before the 1st counted
// from the configured first weekday of the row (1 Sunday .. 7 Saturday, 0 acts as
// Saturday, reset 1), then one cell per day, the final cell flagged with last_cell.
// Years above 9999 are treated as 9999. A month outside 1 to 12 yields a single cell
// with month_error and last_cell set. The weekday comes from the Gregorian day count
// reduced modulo seven (whole 400-year eras drop out), worked through a small
// datapath driven one control word per cycle from a fourteen-step control store.
// The step counter advances one control word per cycle and holds while the output
// register is full. The next item is taken only when the store returns to its idle
// step. Configuration may be written only while idle.
`include "month_calendar_grid_unit_macros.svh"

module month_calendar_grid_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcg_pkg::in_item_t  in_data_i,
  // cell channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcg_pkg::out_item_t out_data_o,
  // week start register
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i
);

  mcg_pkg::step_t      step;
  mcg_pkg::ctrl_word_t ctrl;
  mcg_pkg::dp_status_t status;
  logic                exec;

  // control store lookup for the current step
  mcg_ucode_rom u_rom (
    .step_i (step),
    .ctrl_o (ctrl)
  );

  // step counter, stalls on input wait or a full output register
  mcg_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .status_i   (status),
    .in_valid_i (in_valid_i),
    .step_o     (step),
    .exec_o     (exec),
    .in_ready_o (in_ready_o)
  );

  // arithmetic, counters and the output register
  mcg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .exec_i      (exec),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  // checks
  logic chk_blank;
  logic chk_err;
  logic chk_day;
  logic chk_zero;

  assign chk_blank = out_valid_o && out_data_o.cell_blank;
  assign chk_err   = out_valid_o && out_data_o.month_error;
  assign chk_day   = out_valid_o && !out_data_o.cell_blank && !out_data_o.month_error;
  assign chk_zero  = (out_data_o.day_number == 5'd0);

  // a blank cell carries no day and never closes a run
  `MCG_ASSERT_IMPLY(a_blank_clean, chk_blank, chk_zero && !out_data_o.last_cell && !out_data_o.month_error)
  // an error cell is a lone, closing, empty cell
  `MCG_ASSERT_IMPLY(a_err_single, chk_err, chk_zero && out_data_o.last_cell && !out_data_o.cell_blank)
  // a day cell always has a day from 1 upwards
  `MCG_ASSERT_IMPLY(a_day_nonzero, chk_day, !chk_zero)
  // the sequencer leaves idle right after taking a transaction
  `MCG_ASSERT_NEXT(a_one_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for month_calendar_grid_unit
// depends on mcg_pkg for the request and cell payload types, reads no files

module testbench;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int unsigned StallLimit  = 4000;
  // receiver hold-off long enough to back the block up into its request channel
  localparam int unsigned LongHold    = 400;
  // margin after the last cell, above the worst item latency
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems  = 41;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  mcg_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mcg_pkg::out_item_t out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [2:0]         cfg_wdata_i = 3'd0;

  month_calendar_grid_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // requests waiting for the driver, cells the block still owes us
  mcg_pkg::in_item_t  requests_pending[$];
  mcg_pkg::out_item_t cells_due[$];

  // our copy of the week start register, reset value is sunday
  logic [2:0] week_start = 3'd1;

  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  logic        in_taken     = 1'b0;
  logic        out_taken    = 1'b0;
  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;
  int unsigned hold_left    = 0;
  bit          send_quiet   = 1'b0;
  bit          recv_quiet   = 1'b0;
  bit          hold_ask     = 1'b0;
  bit          hold_served  = 1'b0;

  // gap before the next transaction on one side, none at all in a quiet stretch
  function automatic int unsigned pick_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // expected cells of a month: leading blanks, days 1..length, or one error cell
  function automatic void lay_out_month(input mcg_pkg::in_item_t req,
                                        input logic [2:0] first_col);
    int unsigned        yr, mon, yy, era, yoe, mp, doy, days, wd, lead, len;
    bit                 leap;
    mcg_pkg::out_item_t exp_cell;
    yr  = req.year_value;
    mon = req.month_value;
    if (yr > 9999) yr = 9999;
    if (mon < 1 || mon > 12) begin
      exp_cell = '{cell_blank: 1'b0, day_number: 5'd0, last_cell: 1'b1, month_error: 1'b1};
      cells_due.push_back(exp_cell);
      return;
    end
    // march-based year lifted by one 400-year era so nothing goes negative
    yy   = yr + 400 - ((mon <= 2) ? 1 : 0);
    era  = yy / 400;
    yoe  = yy - era * 400;
    mp   = (mon > 2) ? mon - 3 : mon + 9;
    doy  = (153 * mp + 2) / 5;
    days = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    // day count 865565 is thursday 1970-01-01, weekday 5 with sunday as 1
    wd   = (days + 3) % 7 + 1;
    lead = (wd + 14 - first_col) % 7;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mon)
      2:            len = leap ? 29 : 28;
      4, 6, 9, 11:  len = 30;
      default:      len = 31;
    endcase
    for (int unsigned i = 0; i < lead; i++) begin
      exp_cell = '{cell_blank: 1'b1, day_number: 5'd0, last_cell: 1'b0, month_error: 1'b0};
      cells_due.push_back(exp_cell);
    end
    for (int unsigned d = 1; d <= len; d++) begin
      exp_cell = '{cell_blank: 1'b0, day_number: d[4:0], last_cell: (d == len),
                   month_error: 1'b0};
      cells_due.push_back(exp_cell);
    end
  endfunction

  // mostly well-formed months, some saturated years, a few bad months
  function automatic mcg_pkg::in_item_t random_request();
    mcg_pkg::in_item_t req;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.month_value = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
    end else begin
      req.month_value = 4'($urandom_range(1, 12));
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      req.year_value = 14'($urandom_range(10000, 16383));
    end else if (pick < 25) begin
      // century years, where the leap rule turns on the 400 test
      req.year_value = 14'($urandom_range(0, 99) * 100);
    end else if (pick < 30) begin
      req.year_value = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'd9999;
    end else begin
      req.year_value = 14'($urandom_range(0, 9999));
    end
    return req;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver: one item offered at a time, held until the block takes it
  always @(negedge clk_i) begin
    logic offer;
    offer = in_valid_i;
    if (in_taken) offer = 1'b0;
    if (rst_ni && !offer) begin
      if (send_wait != 0) begin
        send_wait--;
      end else if (requests_pending.size() != 0) begin
        in_data_i <= requests_pending.pop_front();
        offer     = 1'b1;
        send_wait = pick_wait(send_quiet);
      end
    end
    in_valid_i <= offer;
  end

  // cell receiver: random back-pressure per cell, plus one long hold-off on request
  always @(negedge clk_i) begin
    logic take;
    if (out_taken) recv_wait = pick_wait(recv_quiet);
    if (hold_ask && !hold_served) begin
      hold_left   = LongHold;
      hold_served = 1'b1;
    end
    if (!rst_ni) begin
      take = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      take = 1'b0;
    end else if (recv_wait != 0) begin
      recv_wait--;
      take = 1'b0;
    end else begin
      take = 1'b1;
    end
    out_ready_i <= take;
  end

  // request side: predict the cells of every accepted transaction
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) lay_out_month(in_data_i, week_start);
  end

  // cell side: compare every accepted transaction with the oldest expected cell
  always @(posedge clk_i) begin
    mcg_pkg::out_item_t want;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell, expected none actual %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        if (want !== out_data_o) begin
          check_field("cell_blank", want.cell_blank, out_data_o.cell_blank);
          check_field("day_number", want.day_number, out_data_o.day_number);
          check_field("last_cell", want.last_cell, out_data_o.last_cell);
          check_field("month_error", want.month_error, out_data_o.month_error);
          // x or z on the bus compares unequal but slips past the integer checks
          if ($isunknown(out_data_o)) begin
            $display("%0t: cell expected %h actual %h", $time, want, out_data_o);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on a run that stops moving
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("month_calendar_grid_unit verification failed");
    $finish;
  end

  // wait until nothing is queued, offered or owed, then let the block settle
  task automatic drain();
    while (requests_pending.size() != 0 || in_valid_i || cells_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_week_start(input logic [2:0] value);
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    week_start = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_request(input int unsigned yr, input int unsigned mon);
    mcg_pkg::in_item_t req;
    req.year_value  = yr[13:0];
    req.month_value = mon[3:0];
    requests_pending.push_back(req);
  endtask

  initial begin
    logic [2:0] phase_starts[8];
    phase_starts = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset week start (sunday)
    queue_request(1970, 1);    // thursday anchor
    queue_request(0, 1);       // earliest year
    queue_request(0, 2);       // year zero is a leap year
    queue_request(0, 3);
    queue_request(9999, 12);   // latest year
    queue_request(9999, 2);
    queue_request(16383, 15);  // all ones: saturated year and bad month
    queue_request(0, 0);       // month zero
    queue_request(2000, 2);    // divisible by 400, leap
    queue_request(1900, 2);    // divisible by 100 only, not leap
    queue_request(2024, 2);
    queue_request(2023, 2);
    queue_request(2024, 13);
    queue_request(2024, 14);
    queue_request(10000, 2);   // just above the year range, taken as 9999
    queue_request(12345, 7);
    queue_request(2021, 4);    // thirty-day months
    queue_request(2021, 6);
    queue_request(2021, 9);
    queue_request(2021, 11);
    queue_request(2021, 5);
    queue_request(2021, 8);
    queue_request(2021, 10);
    queue_request(2021, 12);
    drain();

    // random phases, each under its own week start, the block idle at every write
    foreach (phase_starts[p]) begin
      write_week_start(phase_starts[p]);
      send_quiet = (p % 3 == 1);
      recv_quiet = (p % 4 == 2);
      for (int n = 0; n < PhaseItems; n++) requests_pending.push_back(random_request());
      // the receiver stalls while back-to-back requests keep arriving
      if (p == 1) hold_ask = 1'b1;
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (cells_due.size() != 0) begin
      $display("%0t: %0d cells expected actual none", $time, cells_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("month_calendar_grid_unit verification clean");
    end else begin
      $display("month_calendar_grid_unit verification failed");
    end
    $finish;
  end

endmodule
